/* src/rptj_pkg.sv */
// ----------------------------------------------------------------------------
// rptj_pkg: shared types, constants and fixed-point helpers
// Widths of the pose, point and row fields, register indexes, and the
// round-to-Q16.16 and saturate functions used by the transform pipeline.
// ----------------------------------------------------------------------------
package rptj_pkg;

  localparam int QUAT_W  = 16;  // Q2.14
  localparam int COORD_W = 32;  // Q16.16
  localparam int FIELD_W = 40;  // result fields, Q24.16
  localparam int AXES    = 3;
  localparam int QN      = 4;

  // exact intermediate widths (Q.30 products and sums)
  localparam int PROD_W  = QUAT_W + COORD_W;     // q * p
  localparam int DSUM_W  = PROD_W + 6;           // sum of 2x and 4x products
  localparam int T_W     = 38;                   // t = 2 (u x p), Q22.16
  localparam int RPROD_W = QUAT_W + T_W;         // q * t
  localparam int WIDE_W  = 64;

  localparam int FRAC_SHIFT = 14;

  localparam int QUEUE_DEPTH = 2;

  // quaternion lane order
  localparam int QI_X = 0;
  localparam int QI_Y = 1;
  localparam int QI_Z = 2;
  localparam int QI_W = 3;

  localparam logic [QUAT_W-1:0] QUAT_ONE = QUAT_W'(16384);

  localparam logic signed [WIDE_W-1:0] ROUND_HALF = 64'sd1 <<< (FRAC_SHIFT - 1);
  localparam logic signed [WIDE_W-1:0] FIELD_MAX  = (64'sd1 <<< (FIELD_W - 1)) - 64'sd1;
  localparam logic signed [WIDE_W-1:0] FIELD_MIN  = -(64'sd1 <<< (FIELD_W - 1));

  typedef enum logic [2:0] {
    CFG_QUAT_X  = 3'd0,
    CFG_QUAT_Y  = 3'd1,
    CFG_QUAT_Z  = 3'd2,
    CFG_QUAT_W  = 3'd3,
    CFG_TRANS_X = 3'd4,
    CFG_TRANS_Y = 3'd5,
    CFG_TRANS_Z = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef struct packed {
    logic signed [QUAT_W-1:0]  qx;
    logic signed [QUAT_W-1:0]  qy;
    logic signed [QUAT_W-1:0]  qz;
    logic signed [QUAT_W-1:0]  qw;
    logic signed [COORD_W-1:0] tx;
    logic signed [COORD_W-1:0] ty;
    logic signed [COORD_W-1:0] tz;
  } cfg_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] coordinate;
    logic signed [FIELD_W-1:0] deriv_qx;
    logic signed [FIELD_W-1:0] deriv_qy;
    logic signed [FIELD_W-1:0] deriv_qz;
    logic signed [FIELD_W-1:0] deriv_qw;
  } row_t;

  typedef row_t [AXES-1:0] rec_t;

  // add half an LSB, then floor: half rounds toward plus infinity
  function automatic logic signed [WIDE_W-1:0] rnd_q14(input logic signed [WIDE_W-1:0] x);
    return (x + ROUND_HALF) >>> FRAC_SHIFT;
  endfunction

  function automatic logic signed [FIELD_W-1:0] sat_field(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] y;
    y = x;
    if (y > FIELD_MAX) y = FIELD_MAX;
    if (y < FIELD_MIN) y = FIELD_MIN;
    return FIELD_W'(y);
  endfunction

endpackage

/* src/rptj_intf.sv */
// ----------------------------------------------------------------------------
// rptj channel interfaces
// Valid/ready channels for input points, result rows and register writes.
// ----------------------------------------------------------------------------
interface rptj_point_if import rptj_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;

  modport source(output valid, output point_x, output point_y, output point_z, input ready);
  modport sink(input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface rptj_row_if import rptj_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [1:0]                axis_index;
  logic                      last_row;
  logic signed [FIELD_W-1:0] coordinate;
  logic signed [FIELD_W-1:0] deriv_qx;
  logic signed [FIELD_W-1:0] deriv_qy;
  logic signed [FIELD_W-1:0] deriv_qz;
  logic signed [FIELD_W-1:0] deriv_qw;

  modport source(output valid, output axis_index, output last_row, output coordinate,
                 output deriv_qx, output deriv_qy, output deriv_qz, output deriv_qw,
                 input ready);
  modport sink(input valid, input axis_index, input last_row, input coordinate,
               input deriv_qx, input deriv_qy, input deriv_qz, input deriv_qw,
               output ready);
endinterface

interface rptj_cfg_if import rptj_pkg::*;;
  logic               valid;
  logic               ready;
  logic [2:0]         index;
  logic [COORD_W-1:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

/* src/rigid_point_transform_jacobian.sv */
// ----------------------------------------------------------------------------
// rigid_point_transform_jacobian: quaternion point transform with Jacobian
// Moves each point by the configured rotation and translation and emits
// three rows (x, y, z) with the new coordinate and its quaternion partials.
//
//   channel   dir  handshake          payload
//   point_i   in   valid/ready        point_x, point_y, point_z
//   row_o     out  valid/ready        axis_index, last_row, coordinate, deriv_q*
//   cfg_i     in   valid/ready (=1)   index, data
//
// Rows leave one per cycle through the single output register while row_o.ready
// holds. The first row passes through the three pipeline stages, the queue and
// the output register.
// Reset loads the identity pose and empties the pipeline and queue.
// A stalled output fills the queue, then the pipeline; point_i.ready drops
// only when every stage holds a point.
// ----------------------------------------------------------------------------
module rigid_point_transform_jacobian import rptj_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rptj_cfg_if.sink    cfg_i,
  rptj_point_if.sink  point_i,
  rptj_row_if.source  row_o
);

  cfg_t cfg_q;
  logic push_valid, push_ready, pop_valid, pop;
  rec_t push_rec, pop_rec;

  assign cfg_i.ready = 1'b1;

  // writes to an unknown index are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{qx: '0, qy: '0, qz: '0, qw: QUAT_ONE, tx: '0, ty: '0, tz: '0};
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_QUAT_X:  cfg_q.qx <= cfg_i.data[QUAT_W-1:0];
        CFG_QUAT_Y:  cfg_q.qy <= cfg_i.data[QUAT_W-1:0];
        CFG_QUAT_Z:  cfg_q.qz <= cfg_i.data[QUAT_W-1:0];
        CFG_QUAT_W:  cfg_q.qw <= cfg_i.data[QUAT_W-1:0];
        CFG_TRANS_X: cfg_q.tx <= cfg_i.data;
        CFG_TRANS_Y: cfg_q.ty <= cfg_i.data;
        CFG_TRANS_Z: cfg_q.tz <= cfg_i.data;
        default: ;
      endcase
    end
  end

  rptj_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .point_i     (point_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_rec_o  (push_rec)
  );

  rptj_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_rec_i  (push_rec),
    .pop_valid_o (pop_valid),
    .pop_i       (pop),
    .pop_rec_o   (pop_rec)
  );

  rptj_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_o      (pop),
    .pop_rec_i  (pop_rec),
    .row_o      (row_o)
  );

endmodule

/* src/rptj_front.sv */
// ----------------------------------------------------------------------------
// rptj_front: three-stage transform pipeline
// Takes points, forms the q*p products, t = 2 (u x p) and the Jacobian
// entries, then the q*t products, and pushes one finished record per point.
// ----------------------------------------------------------------------------
module rptj_front import rptj_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  rptj_point_if.sink        point_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output rec_t              push_rec_o
);

  logic signed [QUAT_W-1:0]  q  [QN];
  logic signed [COORD_W-1:0] tr [AXES];
  logic signed [COORD_W-1:0] pin [AXES];

  logic en1, en2, en3;
  logic v1_q, v2_q, v3_q;

  // stage 1
  logic signed [PROD_W-1:0]  qp_d [QN][AXES];
  logic signed [PROD_W-1:0]  qp_q [QN][AXES];
  logic signed [COORD_W-1:0] p1_q [AXES];

  // stage 2
  logic signed [T_W-1:0]     t_d  [AXES];
  logic signed [T_W-1:0]     t_q  [AXES];
  logic signed [FIELD_W-1:0] dq_d [AXES][QN];
  logic signed [FIELD_W-1:0] dq2_q [AXES][QN];
  logic signed [COORD_W-1:0] p2_q [AXES];

  // stage 3
  logic signed [RPROD_W-1:0] rp_d [AXES][3];
  logic signed [RPROD_W-1:0] rp_q [AXES][3];
  logic signed [FIELD_W-1:0] dq3_q [AXES][QN];
  logic signed [COORD_W-1:0] p3_q [AXES];

  function automatic logic signed [DSUM_W-1:0] ext(input logic signed [PROD_W-1:0] v);
    return DSUM_W'(v);
  endfunction

  function automatic logic signed [FIELD_W-1:0] fin(input logic signed [DSUM_W-1:0] v);
    return sat_field(rnd_q14(WIDE_W'(v)));
  endfunction

  assign q[QI_X] = cfg_i.qx;
  assign q[QI_Y] = cfg_i.qy;
  assign q[QI_Z] = cfg_i.qz;
  assign q[QI_W] = cfg_i.qw;
  assign tr[0]   = cfg_i.tx;
  assign tr[1]   = cfg_i.ty;
  assign tr[2]   = cfg_i.tz;
  assign pin[0]  = point_i.point_x;
  assign pin[1]  = point_i.point_y;
  assign pin[2]  = point_i.point_z;

  // a stage advances when it is empty or its successor advances
  assign en3 = !v3_q || push_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign point_i.ready = en1;
  assign push_valid_o  = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= point_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_comb begin
    for (int i = 0; i < QN; i++) begin
      for (int j = 0; j < AXES; j++) begin
        qp_d[i][j] = PROD_W'(q[i]) * PROD_W'(pin[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      qp_q <= qp_d;
      p1_q <= pin;
    end
  end

  always_comb begin
    t_d[0] = T_W'(rnd_q14(WIDE_W'((ext(qp_q[QI_Y][2]) - ext(qp_q[QI_Z][1])) <<< 1)));
    t_d[1] = T_W'(rnd_q14(WIDE_W'((ext(qp_q[QI_Z][0]) - ext(qp_q[QI_X][2])) <<< 1)));
    t_d[2] = T_W'(rnd_q14(WIDE_W'((ext(qp_q[QI_X][1]) - ext(qp_q[QI_Y][0])) <<< 1)));

    dq_d[0][QI_X] = fin((ext(qp_q[QI_Y][1]) <<< 1) + (ext(qp_q[QI_Z][2]) <<< 1));
    dq_d[1][QI_X] = fin(-(ext(qp_q[QI_W][2]) <<< 1) - (ext(qp_q[QI_X][1]) <<< 2)
                        + (ext(qp_q[QI_Y][0]) <<< 1));
    dq_d[2][QI_X] = fin((ext(qp_q[QI_W][1]) <<< 1) - (ext(qp_q[QI_X][2]) <<< 2)
                        + (ext(qp_q[QI_Z][0]) <<< 1));

    dq_d[0][QI_Y] = fin((ext(qp_q[QI_W][2]) <<< 1) + (ext(qp_q[QI_X][1]) <<< 1)
                        - (ext(qp_q[QI_Y][0]) <<< 2));
    dq_d[1][QI_Y] = fin((ext(qp_q[QI_X][0]) <<< 1) + (ext(qp_q[QI_Z][2]) <<< 1));
    dq_d[2][QI_Y] = fin(-(ext(qp_q[QI_W][0]) <<< 1) - (ext(qp_q[QI_Y][2]) <<< 2)
                        + (ext(qp_q[QI_Z][1]) <<< 1));

    dq_d[0][QI_Z] = fin(-(ext(qp_q[QI_W][1]) <<< 1) + (ext(qp_q[QI_X][2]) <<< 1)
                        - (ext(qp_q[QI_Z][0]) <<< 2));
    dq_d[1][QI_Z] = fin((ext(qp_q[QI_W][0]) <<< 1) + (ext(qp_q[QI_Y][2]) <<< 1)
                        - (ext(qp_q[QI_Z][1]) <<< 2));
    dq_d[2][QI_Z] = fin((ext(qp_q[QI_X][0]) <<< 1) + (ext(qp_q[QI_Y][1]) <<< 1));

    dq_d[0][QI_W] = fin((ext(qp_q[QI_Y][2]) <<< 1) - (ext(qp_q[QI_Z][1]) <<< 1));
    dq_d[1][QI_W] = fin((ext(qp_q[QI_Z][0]) <<< 1) - (ext(qp_q[QI_X][2]) <<< 1));
    dq_d[2][QI_W] = fin((ext(qp_q[QI_X][1]) <<< 1) - (ext(qp_q[QI_Y][0]) <<< 1));
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      t_q   <= t_d;
      dq2_q <= dq_d;
      p2_q  <= p1_q;
    end
  end

  // per axis: w*t_k, then the two terms of u x t (added, subtracted)
  always_comb begin
    rp_d[0][0] = RPROD_W'(q[QI_W]) * RPROD_W'(t_q[0]);
    rp_d[0][1] = RPROD_W'(q[QI_Y]) * RPROD_W'(t_q[2]);
    rp_d[0][2] = RPROD_W'(q[QI_Z]) * RPROD_W'(t_q[1]);
    rp_d[1][0] = RPROD_W'(q[QI_W]) * RPROD_W'(t_q[1]);
    rp_d[1][1] = RPROD_W'(q[QI_Z]) * RPROD_W'(t_q[0]);
    rp_d[1][2] = RPROD_W'(q[QI_X]) * RPROD_W'(t_q[2]);
    rp_d[2][0] = RPROD_W'(q[QI_W]) * RPROD_W'(t_q[2]);
    rp_d[2][1] = RPROD_W'(q[QI_X]) * RPROD_W'(t_q[1]);
    rp_d[2][2] = RPROD_W'(q[QI_Y]) * RPROD_W'(t_q[0]);
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      rp_q  <= rp_d;
      dq3_q <= dq2_q;
      p3_q  <= p2_q;
    end
  end

  always_comb begin
    logic signed [WIDE_W-1:0] rsum;
    for (int k = 0; k < AXES; k++) begin
      rsum = WIDE_W'(rp_q[k][0]) + WIDE_W'(rp_q[k][1]) - WIDE_W'(rp_q[k][2]);
      push_rec_o[k].coordinate = sat_field(WIDE_W'(p3_q[k]) + rnd_q14(rsum)
                                           + WIDE_W'(tr[k]));
      push_rec_o[k].deriv_qx   = dq3_q[k][QI_X];
      push_rec_o[k].deriv_qy   = dq3_q[k][QI_Y];
      push_rec_o[k].deriv_qz   = dq3_q[k][QI_Z];
      push_rec_o[k].deriv_qw   = dq3_q[k][QI_W];
    end
  end

endmodule

/* src/rptj_queue.sv */
// ----------------------------------------------------------------------------
// rptj_queue: record queue between transform pipeline and row sequencer
// Small FIFO of finished point records; full and empty from a fill count.
// ----------------------------------------------------------------------------
module rptj_queue import rptj_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  rec_t push_rec_i,
  output logic pop_valid_o,
  input  logic pop_i,
  output rec_t pop_rec_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  rec_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != Full);
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_rec_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    if (pop)  rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    if (push && !pop) cnt_d = cnt_q + 1'b1;
    else if (pop && !push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_rec_i;
  end

endmodule

/* src/rptj_back.sv */
// ----------------------------------------------------------------------------
// rptj_back: row sequencer and output register
// Walks the head record through its x, y and z rows, one row per cycle while
// the output is not stalled, and releases the record as the z row is loaded.
// ----------------------------------------------------------------------------
module rptj_back import rptj_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  output logic       pop_o,
  input  rec_t       pop_rec_i,
  rptj_row_if.source row_o
);

  axis_e row_q, row_d;
  logic  out_valid_q;
  logic  load;
  row_t  sel;
  row_t  out_q;
  axis_e out_axis_q;
  logic  out_last_q;

  assign load  = pop_valid_i && (!out_valid_q || row_o.ready);
  assign pop_o = load && (row_q == AXIS_Z);

  always_comb begin
    case (row_q)
      AXIS_X: begin
        sel   = pop_rec_i[0];
        row_d = AXIS_Y;
      end
      AXIS_Y: begin
        sel   = pop_rec_i[1];
        row_d = AXIS_Z;
      end
      AXIS_Z: begin
        sel   = pop_rec_i[2];
        row_d = AXIS_X;
      end
      default: begin
        sel   = pop_rec_i[0];
        row_d = AXIS_X;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= AXIS_X;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        row_q       <= row_d;
        out_valid_q <= 1'b1;
      end else if (row_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q      <= sel;
      out_axis_q <= row_q;
      out_last_q <= (row_q == AXIS_Z);
    end
  end

  assign row_o.valid      = out_valid_q;
  assign row_o.axis_index = out_axis_q;
  assign row_o.last_row   = out_last_q;
  assign row_o.coordinate = out_q.coordinate;
  assign row_o.deriv_qx   = out_q.deriv_qx;
  assign row_o.deriv_qy   = out_q.deriv_qy;
  assign row_o.deriv_qz   = out_q.deriv_qz;
  assign row_o.deriv_qw   = out_q.deriv_qw;

endmodule

/* sim/rigid_point_transform_jacobian_tb.sv */
// ----------------------------------------------------------------------------
// rigid_point_transform_jacobian_tb: self-checking bench for the pose transform
// Loads poses through the register channel, streams points in and checks
// every row (axis, coordinate, quaternion partials) against a fixed-point
// predictor kept in step with the register writes. Both channel ends stall
// at random; a watchdog ends a hung run.
// ----------------------------------------------------------------------------
module rigid_point_transform_jacobian_tb;
  import rptj_pkg::*;

  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          TAIL_CYCLES    = 10;
  localparam logic [2:0]  CFG_IDX_UNUSED = 3'd7;
  localparam axis_e       AXIS_OF[AXES]  = '{AXIS_X, AXIS_Y, AXIS_Z};
  localparam logic signed [COORD_W-1:0] P_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] P_MIN = 32'sh8000_0000;
  localparam logic signed [QUAT_W-1:0]  Q_MAX = 16'sh7FFF;
  localparam logic signed [QUAT_W-1:0]  Q_MIN = 16'sh8000;

  typedef struct packed {
    logic [1:0] axis;
    logic       last;
    row_t       vals;
  } pose_row_t;

  logic clk = 1'b0;
  logic rst_n;

  rptj_cfg_if   cfg_if();
  rptj_point_if pt_if();
  rptj_row_if   row_if();

  rigid_point_transform_jacobian u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .cfg_i   (cfg_if),
    .point_i (pt_if),
    .row_o   (row_if)
  );

  cfg_t      pose_model;
  pose_row_t pending_rows[$];
  int        row_mismatches;
  int        rows_seen;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        stall_cycles;

  always #4 clk = ~clk;

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------
  function automatic longint round_q14(input longint x);
    return (x + 64'sd8192) >>> FRAC_SHIFT;
  endfunction

  function automatic logic signed [FIELD_W-1:0] clamp_field(input longint x);
    if (x > FIELD_MAX) return FIELD_MAX[FIELD_W-1:0];
    if (x < FIELD_MIN) return FIELD_MIN[FIELD_W-1:0];
    return x[FIELD_W-1:0];
  endfunction

  function automatic void predict_rows(input logic signed [COORD_W-1:0] p_x,
                                       input logic signed [COORD_W-1:0] p_y,
                                       input logic signed [COORD_W-1:0] p_z);
    longint    px, py, pz, qx, qy, qz, qw, tx, ty, tz;
    longint    coord[AXES], dx[AXES], dy[AXES], dz[AXES], dw[AXES];
    pose_row_t r;
    px = p_x;
    py = p_y;
    pz = p_z;
    qx = $signed(pose_model.qx);
    qy = $signed(pose_model.qy);
    qz = $signed(pose_model.qz);
    qw = $signed(pose_model.qw);

    // rotation vector t = 2 (u x p), rounded to Q16.16
    tx = round_q14(2 * (qy * pz - qz * py));
    ty = round_q14(2 * (qz * px - qx * pz));
    tz = round_q14(2 * (qx * py - qy * px));

    coord[0] = px + round_q14(qw * tx + (qy * tz - qz * ty)) + longint'($signed(pose_model.tx));
    coord[1] = py + round_q14(qw * ty + (qz * tx - qx * tz)) + longint'($signed(pose_model.ty));
    coord[2] = pz + round_q14(qw * tz + (qx * ty - qy * tx)) + longint'($signed(pose_model.tz));

    dx[0] = 2 * qy * py + 2 * qz * pz;
    dx[1] = -2 * qw * pz - 4 * qx * py + 2 * qy * px;
    dx[2] = 2 * qw * py - 4 * qx * pz + 2 * qz * px;

    dy[0] = 2 * qw * pz + 2 * qx * py - 4 * qy * px;
    dy[1] = 2 * qx * px + 2 * qz * pz;
    dy[2] = -2 * qw * px - 4 * qy * pz + 2 * qz * py;

    dz[0] = -2 * qw * py + 2 * qx * pz - 4 * qz * px;
    dz[1] = 2 * qw * px + 2 * qy * pz - 4 * qz * py;
    dz[2] = 2 * qx * px + 2 * qy * py;

    dw[0] = 2 * qy * pz - 2 * qz * py;
    dw[1] = -2 * qx * pz + 2 * qz * px;
    dw[2] = 2 * qx * py - 2 * qy * px;

    for (int k = 0; k < AXES; k++) begin
      r.axis = AXIS_OF[k];
      r.last = (AXIS_OF[k] == AXIS_Z);
      r.vals.coordinate = clamp_field(coord[k]);
      r.vals.deriv_qx = clamp_field(round_q14(dx[k]));
      r.vals.deriv_qy = clamp_field(round_q14(dy[k]));
      r.vals.deriv_qz = clamp_field(round_q14(dz[k]));
      r.vals.deriv_qw = clamp_field(round_q14(dw[k]));
      pending_rows.push_back(r);
    end
  endfunction

  // ------------------------------------------------------------------------
  // Row checker, receiver stalls, watchdog
  // ------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("ERROR row %0d: %s", rows_seen, msg);
    row_mismatches++;
  endtask

  task automatic check_field(input string name, input logic signed [FIELD_W-1:0] got,
                             input logic signed [FIELD_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin
    row_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    pose_row_t want;
    if (rst_n && row_if.valid && row_if.ready) begin
      if (pending_rows.size() == 0) begin
        report_mismatch($sformatf("row with no point outstanding, axis %0d",
                                  row_if.axis_index));
      end else begin
        want = pending_rows.pop_front();
        check_field("axis_index", FIELD_W'(row_if.axis_index), FIELD_W'(want.axis));
        check_field("last_row", FIELD_W'(row_if.last_row), FIELD_W'(want.last));
        check_field("coordinate", row_if.coordinate, want.vals.coordinate);
        check_field("deriv_qx", row_if.deriv_qx, want.vals.deriv_qx);
        check_field("deriv_qy", row_if.deriv_qy, want.vals.deriv_qy);
        check_field("deriv_qz", row_if.deriv_qz, want.vals.deriv_qz);
        check_field("deriv_qw", row_if.deriv_qw, want.vals.deriv_qw);
      end
      rows_seen++;
    end
  end

  always @(posedge clk) begin
    if ((pt_if.valid && pt_if.ready) || (row_if.valid && row_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !rst_n) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR watchdog: no transfer in %0d cycles", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ------------------------------------------------------------------------
  // Drivers
  // ------------------------------------------------------------------------
  task automatic send_point(input logic signed [COORD_W-1:0] p_x,
                            input logic signed [COORD_W-1:0] p_y,
                            input logic signed [COORD_W-1:0] p_z);
    while ($urandom_range(99) < send_idle_pct) begin
      pt_if.valid <= 1'b0;
      @(posedge clk);
    end
    pt_if.valid <= 1'b1;
    pt_if.point_x <= p_x;
    pt_if.point_y <= p_y;
    pt_if.point_z <= p_z;
    @(posedge clk);
    while (!pt_if.ready) @(posedge clk);
    predict_rows(p_x, p_y, p_z);
  endtask

  // hold off new points until every outstanding row has been taken
  task automatic drain_rows();
    pt_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_rows.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [COORD_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      CFG_QUAT_X:  pose_model.qx = data[QUAT_W-1:0];
      CFG_QUAT_Y:  pose_model.qy = data[QUAT_W-1:0];
      CFG_QUAT_Z:  pose_model.qz = data[QUAT_W-1:0];
      CFG_QUAT_W:  pose_model.qw = data[QUAT_W-1:0];
      CFG_TRANS_X: pose_model.tx = data;
      CFG_TRANS_Y: pose_model.ty = data;
      CFG_TRANS_Z: pose_model.tz = data;
      default: ;
    endcase
  endtask

  // junk in the upper half of quaternion writes must be dropped by the block
  task automatic load_pose(input logic signed [QUAT_W-1:0] qx, input logic signed [QUAT_W-1:0] qy,
                           input logic signed [QUAT_W-1:0] qz, input logic signed [QUAT_W-1:0] qw,
                           input logic signed [COORD_W-1:0] tx,
                           input logic signed [COORD_W-1:0] ty,
                           input logic signed [COORD_W-1:0] tz);
    write_reg(CFG_QUAT_X, {16'($urandom), qx});
    write_reg(CFG_QUAT_Y, {16'($urandom), qy});
    write_reg(CFG_QUAT_Z, {16'($urandom), qz});
    write_reg(CFG_QUAT_W, {16'($urandom), qw});
    write_reg(CFG_TRANS_X, tx);
    write_reg(CFG_TRANS_Y, ty);
    write_reg(CFG_TRANS_Z, tz);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [COORD_W-1:0] rand_coord();
    if ($urandom_range(3) == 0) return $urandom;
    return $signed(32'($urandom_range(2097151))) - 32'sd1048576;
  endfunction

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  task automatic test_identity_pose();
    send_point(32'sd0, 32'sd0, 32'sd0);
    send_point(P_MAX, P_MAX, P_MAX);
    send_point(P_MIN, P_MIN, P_MIN);
    send_point(P_MAX, P_MIN, 32'sd1);
    send_point(-32'sd1, 32'sh0001_0000, -32'sh0000_8000);
    drain_rows();
  endtask

  task automatic test_pose_extremes();
    load_pose(Q_MIN, Q_MIN, Q_MIN, Q_MIN, P_MAX, P_MAX, P_MAX);
    send_point(P_MAX, P_MIN, P_MAX);
    send_point(P_MIN, P_MAX, P_MIN);
    drain_rows();
    load_pose(Q_MAX, Q_MAX, Q_MAX, Q_MAX, P_MIN, P_MIN, P_MIN);
    send_point(P_MIN, P_MIN, P_MIN);
    send_point(P_MAX, P_MAX, P_MAX);
    drain_rows();
    load_pose(Q_MAX, Q_MIN, Q_MAX, Q_MIN, P_MAX, P_MIN, P_MAX);
    send_point(P_MAX, P_MIN, P_MIN);
    drain_rows();
  endtask

  task automatic test_unused_index_and_rotation();
    // 90 degrees about z; the write to the unused index must change nothing
    write_reg(CFG_IDX_UNUSED, $urandom);
    load_pose(16'sd0, 16'sd0, 16'sd11585, 16'sd11585,
              32'sh0001_0000, -32'sh0002_0000, 32'sh7FFF_FFFF);
    write_reg(CFG_IDX_UNUSED, $urandom);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
    send_point(32'sh0001_0000, 32'sd0, 32'sd0);
    send_point(32'sd0, 32'sh0001_0000, 32'sd0);
    send_point(32'sh0001_2345, -32'sh0000_6789, 32'sh0080_0000);
    drain_rows();
  endtask

  task automatic test_non_unit_quaternion();
    // tiny components put many products on a rounding half
    load_pose(16'sd1, -16'sd1, 16'sd2, -16'sd2, 32'sd0, 32'sd1, -32'sd1);
    send_point(32'sd3, 32'sd5, 32'sd7);
    send_point(-32'sd4096, 32'sd8192, -32'sd12288);
    drain_rows();
    load_pose(16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'sd5, -32'sd5, 32'sd0);
    send_point(32'sh1234_5678, -32'sh0765_4321, 32'sd1);
    drain_rows();
  endtask

  task automatic test_random_points();
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 30; recv_idle_pct = 86; end
        1: begin send_idle_pct = 86; recv_idle_pct = 30; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (phase == 1)
        load_pose(16'sd8192, -16'sd8192, 16'sd8192, 16'sd8192, $urandom, $urandom, $urandom);
      else
        load_pose(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  $urandom, $urandom, $urandom);
      for (int n = 0; n < 37; n++) begin
        send_point(rand_coord(), rand_coord(), rand_coord());
        if (n == 18) drain_rows();
      end
      drain_rows();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    pt_if.valid = 1'b0;
    pt_if.point_x = '0;
    pt_if.point_y = '0;
    pt_if.point_z = '0;
    send_idle_pct = 30;
    recv_idle_pct = 86;
    pose_model = '0;
    pose_model.qw = QUAT_ONE;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_identity_pose();
    test_pose_extremes();
    test_unused_index_and_rotation();
    test_non_unit_quaternion();
    test_random_points();
    drain_rows();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (row_mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
src/rptj_pkg.sv
src/rptj_intf.sv
src/rptj_front.sv
src/rptj_queue.sv
src/rptj_back.sv
src/rigid_point_transform_jacobian.sv
sim/rigid_point_transform_jacobian_tb.sv
